[design/shll_pkg.sv]
// shll_pkg: field widths, packing offsets and the leading-zero helper
// for the sliding-window HyperLogLog epoch store. No dependencies.
package shll_pkg;

  localparam int BUCKET_BITS_DEF = 10;

  localparam int HASH_W   = 32;
  localparam int EPOCH_W  = 32;
  localparam int BUCKET_W = 10;
  localparam int RANK_W   = 5;

  // Input tdata layout, lowest bit first.
  localparam int IN_HASH_LO   = 0;
  localparam int IN_EPOCH_LO  = IN_HASH_LO + HASH_W;
  localparam int IN_BUCKET_LO = IN_EPOCH_LO + EPOCH_W;
  localparam int IN_MINEP_LO  = IN_BUCKET_LO + BUCKET_W;
  localparam int IN_BITS      = IN_MINEP_LO + EPOCH_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

  // Output tdata layout, lowest bit first.
  localparam int OUT_BITS    = RANK_W + BUCKET_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // tuser codes.
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Leading-zero count of a 32-bit word, binary search in five halving steps.
  function automatic logic [5:0] lzc32(input logic [31:0] x);
    logic [31:0] v;
    logic [5:0]  n;
    v = x;
    n = 6'd0;
    if (v == 32'd0) begin
      n = 6'd32;
    end else begin
      if (v[31:16] == 16'd0) begin
        n = n + 6'd16;
        v = v << 16;
      end
      if (v[31:24] == 8'd0) begin
        n = n + 6'd8;
        v = v << 8;
      end
      if (v[31:28] == 4'd0) begin
        n = n + 6'd4;
        v = v << 4;
      end
      if (v[31:30] == 2'd0) begin
        n = n + 6'd2;
        v = v << 2;
      end
      if (v[31] == 1'b0) begin
        n = n + 6'd1;
      end
    end
    return n;
  endfunction

endpackage

[design/shll_mem.sv]
// shll_mem: single-port-write, single-port-read epoch memory with a
// registered read. Depends on no package.
module shll_mem #(
  parameter int DEPTH  = 23552,
  parameter int ADDR_W = 15,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/shll_cmp.sv]
// shll_cmp: the shared unsigned epoch comparator, used by both the add
// update test and the query window test. Depends on shll_pkg.
module shll_cmp (
  input  logic [shll_pkg::EPOCH_W-1:0] lhs,
  input  logic [shll_pkg::EPOCH_W-1:0] rhs,
  output logic                         ge
);

  assign ge = (lhs >= rhs);

endmodule

[design/sliding_hll_epoch_store.sv]
// sliding_hll_epoch_store: add is a read, then a conditional write.
// Query scans 1..NUM_RANKS ranks from the top down,
// one memory read and one compare per cycle; one request in flight at a time.
// The output register lets a new request enter while a result waits.
// rst is synchronous; after it a clearing pass zeroes all NUM_RANKS * NUM_BUCKETS
// entries (23552 by default), with s_tready low throughout.
module sliding_hll_epoch_store #(
  parameter int BUCKET_BITS = shll_pkg::BUCKET_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // hash_value[31:0], epoch[63:32], bucket[73:64], min_epoch[105:74], zero pad
  input  logic [shll_pkg::IN_TDATA_W-1:0]  s_tdata,
  // func[0]
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // rank[4:0], bucket_echo[14:5], zero pad
  output logic [shll_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
  localparam int NUM_RANKS   = 33 - BUCKET_BITS;
  localparam int RIDX_W      = $clog2(NUM_RANKS);
  localparam int ADDR_W      = RIDX_W + BUCKET_BITS;
  localparam int DEPTH       = NUM_RANKS * NUM_BUCKETS;
  localparam int WIDE_W      = (BUCKET_BITS > shll_pkg::BUCKET_W) ?
                               BUCKET_BITS : shll_pkg::BUCKET_W;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_ADD_WR = 6'b000100,
    ST_Q_CHK  = 6'b001000,
    ST_Q_OUT  = 6'b010000,
    ST_SPARE  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [ADDR_W-1:0]              clr_addr;
  logic [RIDX_W-1:0]              ridx;
  logic [BUCKET_BITS-1:0]         bkt;
  logic [shll_pkg::EPOCH_W-1:0]   key;
  logic [shll_pkg::RANK_W-1:0]    rank_q;
  logic [shll_pkg::RANK_W-1:0]    rank_out;
  logic [shll_pkg::BUCKET_W-1:0]  echo_out;

  // Request decode.
  logic [shll_pkg::HASH_W-1:0]    in_hash;
  logic [shll_pkg::EPOCH_W-1:0]   in_epoch;
  logic [shll_pkg::BUCKET_W-1:0]  in_bucket;
  logic [shll_pkg::EPOCH_W-1:0]   in_minep;
  logic [WIDE_W-1:0]              in_bkt_wide;
  logic [BUCKET_BITS-1:0]         q_bkt;
  logic [BUCKET_BITS-1:0]         a_bkt;
  logic [shll_pkg::HASH_W-1:0]    rest;
  logic [5:0]                     lz;
  logic [5:0]                     rk;
  logic [RIDX_W-1:0]              a_ridx;
  logic [WIDE_W-1:0]              bkt_wide;

  logic                           accept;
  logic                           out_free;
  logic                           mem_we;
  logic [ADDR_W-1:0]              mem_waddr;
  logic [shll_pkg::EPOCH_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]              mem_raddr;
  logic [shll_pkg::EPOCH_W-1:0]   mem_rdata;
  logic                           ge;

  assign in_hash   = s_tdata[shll_pkg::IN_HASH_LO   +: shll_pkg::HASH_W];
  assign in_epoch  = s_tdata[shll_pkg::IN_EPOCH_LO  +: shll_pkg::EPOCH_W];
  assign in_bucket = s_tdata[shll_pkg::IN_BUCKET_LO +: shll_pkg::BUCKET_W];
  assign in_minep  = s_tdata[shll_pkg::IN_MINEP_LO  +: shll_pkg::EPOCH_W];

  // Wrap the query bucket to the store's bucket count.
  assign in_bkt_wide = WIDE_W'(in_bucket);
  assign q_bkt       = in_bkt_wide[BUCKET_BITS-1:0];

  assign a_bkt = in_hash[shll_pkg::HASH_W-1 -: BUCKET_BITS];
  assign rest  = in_hash << BUCKET_BITS;
  assign lz    = shll_pkg::lzc32(rest);

  always_comb begin
    if (rest == '0) begin
      rk = 6'(NUM_RANKS);
    end else begin
      rk = lz + 6'd1;
    end
    if (rk > 6'(NUM_RANKS)) begin
      rk = 6'(NUM_RANKS);
    end
  end
  assign a_ridx = RIDX_W'(rk - 6'd1);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    case (state)
      ST_IDLE: begin
        if (s_tuser == shll_pkg::FUNC_QUERY) begin
          mem_raddr = {RIDX_W'(NUM_RANKS - 1), q_bkt};
        end else begin
          mem_raddr = {a_ridx, a_bkt};
        end
      end
      ST_Q_CHK: mem_raddr = {ridx - RIDX_W'(1), bkt};
      default:  mem_raddr = {ridx, bkt};
    endcase
  end

  always_comb begin
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_ADD_WR: begin
        mem_we    = !ge;
        mem_waddr = {ridx, bkt};
        mem_wdata = key;
      end
      default: begin
        mem_we    = 1'b0;
        mem_waddr = {ridx, bkt};
        mem_wdata = key;
      end
    endcase
  end

  shll_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (shll_pkg::EPOCH_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  shll_cmp u_cmp (
    .lhs (mem_rdata),
    .rhs (key),
    .ge  (ge)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = (s_tuser == shll_pkg::FUNC_QUERY) ? ST_Q_CHK : ST_ADD_WR;
        end
      end
      ST_ADD_WR: state_next = ST_IDLE;
      ST_Q_CHK: begin
        if (ge || ridx == '0) begin
          state_next = ST_Q_OUT;
        end
      end
      ST_Q_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == ST_Q_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign bkt_wide = WIDE_W'(bkt);

  always_ff @(posedge clk) begin
    if (accept) begin
      if (s_tuser == shll_pkg::FUNC_QUERY) begin
        ridx <= RIDX_W'(NUM_RANKS - 1);
        bkt  <= q_bkt;
        key  <= in_minep;
      end else begin
        ridx <= a_ridx;
        bkt  <= a_bkt;
        key  <= in_epoch;
      end
    end else if (state == ST_Q_CHK) begin
      if (ge) begin
        rank_q <= shll_pkg::RANK_W'(ridx) + shll_pkg::RANK_W'(1);
      end else if (ridx == '0) begin
        rank_q <= '0;
      end else begin
        // Step down to the next lower rank; its read is already issued.
        ridx <= ridx - RIDX_W'(1);
      end
    end
    if (state == ST_Q_OUT && out_free) begin
      rank_out <= rank_q;
      echo_out <= bkt_wide[shll_pkg::BUCKET_W-1:0];
    end
  end

  assign m_tdata = shll_pkg::OUT_TDATA_W'({echo_out, rank_out});

  // A request leaves the idle state on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("request accepted but sequencer stayed idle");

  // A query scan never writes the store.
  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_Q_CHK) |-> !mem_we)
    else $error("store written during query scan");

  // The scan index stays inside the rank range.
  a_ridx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_Q_CHK) |-> (ridx < RIDX_W'(NUM_RANKS)))
    else $error("query scan rank out of range");

  // A result appears only after the query output step.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_Q_OUT))
    else $error("result raised outside query output step");

endmodule
